// File: hw/rtl/dds_pkg.sv
// Shared types, constants and the sine table of the DDS waveform generator.
package dds_pkg;

  localparam int PHASE_W  = 32;
  localparam int CODE_W   = 12;
  localparam int GAIN_W   = 16;
  localparam int FRAC_W   = 16;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  localparam logic [CODE_W-1:0]   MID_CODE  = 12'd2048;
  localparam logic [CODE_W-1:0]   MAX_CODE  = 12'd4095;
  localparam logic [GAIN_W-1:0]   FULL_GAIN = 16'd32768;
  localparam logic [GAIN_W-1:0]   AMP_RESET = 16'd19859;
  localparam logic [9:0]          TRI_HALF  = 10'd512;
  localparam logic [9:0]          TRI_TOP   = 10'd1023;

  typedef enum logic [1:0] {
    SHAPE_SINE   = 2'd0,
    SHAPE_TRI    = 2'd1,
    SHAPE_SQUARE = 2'd2,
    SHAPE_SINE_X = 2'd3
  } shape_t;

  typedef enum logic [1:0] {
    REG_PHASE_STEP  = 2'd0,
    REG_WAVE_SHAPE  = 2'd1,
    REG_AMP_SCALE   = 2'd2,
    REG_START_PHASE = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_INTERP = 2'd1,
    ST_SCALE = 2'd2,
    ST_OUT   = 2'd3
  } state_t;

  typedef logic [CODE_W-1:0] code_t;

  localparam code_t SIN_ROM [256] = '{
    12'd2048,12'd2098,12'd2148,12'd2199,12'd2249,12'd2299,12'd2348,12'd2398,
    12'd2447,12'd2497,12'd2545,12'd2594,12'd2642,12'd2690,12'd2738,12'd2785,
    12'd2831,12'd2878,12'd2923,12'd2968,12'd3013,12'd3057,12'd3100,12'd3143,
    12'd3185,12'd3227,12'd3267,12'd3307,12'd3347,12'd3385,12'd3423,12'd3459,
    12'd3495,12'd3531,12'd3565,12'd3598,12'd3630,12'd3662,12'd3692,12'd3722,
    12'd3750,12'd3777,12'd3804,12'd3829,12'd3853,12'd3876,12'd3898,12'd3919,
    12'd3939,12'd3958,12'd3975,12'd3992,12'd4007,12'd4021,12'd4034,12'd4045,
    12'd4056,12'd4065,12'd4073,12'd4080,12'd4085,12'd4089,12'd4093,12'd4094,
    12'd4095,12'd4094,12'd4093,12'd4089,12'd4085,12'd4080,12'd4073,12'd4065,
    12'd4056,12'd4045,12'd4034,12'd4021,12'd4007,12'd3992,12'd3975,12'd3958,
    12'd3939,12'd3919,12'd3898,12'd3876,12'd3853,12'd3829,12'd3804,12'd3777,
    12'd3750,12'd3722,12'd3692,12'd3662,12'd3630,12'd3598,12'd3565,12'd3531,
    12'd3495,12'd3459,12'd3423,12'd3385,12'd3347,12'd3307,12'd3267,12'd3227,
    12'd3185,12'd3143,12'd3100,12'd3057,12'd3013,12'd2968,12'd2923,12'd2878,
    12'd2831,12'd2785,12'd2738,12'd2690,12'd2642,12'd2594,12'd2545,12'd2497,
    12'd2447,12'd2398,12'd2348,12'd2299,12'd2249,12'd2199,12'd2148,12'd2098,
    12'd2048,12'd1998,12'd1948,12'd1897,12'd1847,12'd1797,12'd1748,12'd1698,
    12'd1649,12'd1599,12'd1551,12'd1502,12'd1454,12'd1406,12'd1358,12'd1311,
    12'd1265,12'd1218,12'd1173,12'd1128,12'd1083,12'd1039,12'd996,12'd953,
    12'd911,12'd869,12'd829,12'd789,12'd749,12'd711,12'd673,12'd637,
    12'd601,12'd565,12'd531,12'd498,12'd466,12'd434,12'd404,12'd374,
    12'd346,12'd319,12'd292,12'd267,12'd243,12'd220,12'd198,12'd177,
    12'd157,12'd138,12'd121,12'd104,12'd89,12'd75,12'd62,12'd51,
    12'd40,12'd31,12'd23,12'd16,12'd11,12'd7,12'd3,12'd2,
    12'd1,12'd2,12'd3,12'd7,12'd11,12'd16,12'd23,12'd31,
    12'd40,12'd51,12'd62,12'd75,12'd89,12'd104,12'd121,12'd138,
    12'd157,12'd177,12'd198,12'd220,12'd243,12'd267,12'd292,12'd319,
    12'd346,12'd374,12'd404,12'd434,12'd466,12'd498,12'd531,12'd565,
    12'd601,12'd637,12'd673,12'd711,12'd749,12'd789,12'd829,12'd869,
    12'd911,12'd953,12'd996,12'd1039,12'd1083,12'd1128,12'd1173,12'd1218,
    12'd1265,12'd1311,12'd1358,12'd1406,12'd1454,12'd1502,12'd1551,12'd1599,
    12'd1649,12'd1698,12'd1748,12'd1797,12'd1847,12'd1897,12'd1948,12'd1998
  };

endpackage

// File: hw/rtl/dds_in_if.sv
// Tick channel: valid/ready handshake carrying the restart flag.
interface dds_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// File: hw/rtl/dds_out_if.sv
// Sample channel: valid/ready handshake carrying one 12-bit DAC code.
interface dds_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: hw/rtl/dds_interp_waveform_generator_core.sv
// Top level of the DDS waveform generator: phase accumulator, sine ROM, scaler.
//
// Each tick beat produces one 12-bit sample beat. From acceptance to a valid
// sample an item passes these steps in order: the accept step registers both
// neighboring sine ROM entries and advances the accumulator, then the
// interpolation multiply (ST_INTERP), the amplitude multiply (ST_SCALE), and
// ST_OUT, which recenters, clamps and loads the output register.
// A new tick is taken only once the previous sample has been loaded; a stalled
// sink holds the last step until the output register frees. Triangle and square
// shapes follow the same path. Registers sit on an APB port at byte addresses
// 0, 4, 8 and 12 (phase_step, wave_shape, amp_scale, start_phase) and must be
// written only while idle, which the block itself does not enforce.
module dds_interp_waveform_generator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  dds_in_if.sink                      in_ch,
  dds_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dds_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [dds_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [dds_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import dds_pkg::*;

  // configuration registers
  logic [PHASE_W-1:0] phase_step_r;
  shape_t             wave_shape_r;
  logic [GAIN_W-1:0]  amp_scale_r;
  logic [PHASE_W-1:0] start_phase_r;

  // datapath state
  logic [PHASE_W-1:0] accum_r;
  logic [PHASE_W-1:0] phase_r;
  code_t              v0_r;
  code_t              v1_r;
  logic               interp_neg_r;
  code_t              interp_q_r;
  logic               scale_neg_r;
  logic [12:0]        scale_q_r;
  code_t              sample_r;
  logic               out_valid_r;
  state_t             state_r;
  state_t             state_nxt;

  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  logic               accept;
  logic               load_out;
  logic               in_ready;
  logic [PHASE_W-1:0] phase_sel;
  logic [7:0]         rom_idx;
  logic [7:0]         rom_idx_next;

  logic [12:0]        diff;
  code_t              diff_mag;
  logic [27:0]        interp_prod;
  logic [12:0]        raw;
  logic [9:0]         tri_pos;
  logic [9:0]         tri_lin;
  logic [13:0]        centered;
  code_t              centered_mag;
  logic [GAIN_W-1:0]  gain;
  logic [27:0]        scale_prod;
  logic [13:0]        sum;
  code_t              sample_nxt;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r  <= '0;
      wave_shape_r  <= SHAPE_SINE;
      amp_scale_r   <= AMP_RESET;
      start_phase_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PHASE_STEP:  phase_step_r  <= cfg_pwdata;
        REG_WAVE_SHAPE:  wave_shape_r  <= shape_t'(cfg_pwdata[1:0]);
        REG_AMP_SCALE:   amp_scale_r   <= cfg_pwdata[GAIN_W-1:0];
        REG_START_PHASE: start_phase_r <= cfg_pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PHASE_STEP:  cfg_prdata = phase_step_r;
      REG_WAVE_SHAPE:  cfg_prdata = {{(CFG_DW-2){1'b0}}, wave_shape_r};
      REG_AMP_SCALE:   cfg_prdata = {{(CFG_DW-GAIN_W){1'b0}}, amp_scale_r};
      REG_START_PHASE: cfg_prdata = start_phase_r;
    endcase
  end

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_INTERP;
      ST_INTERP: state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_OUT;
      ST_OUT:    if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_INTERP: ;
      ST_SCALE:  ;
      ST_OUT:    load_out = !out_valid_r || out_ch.ready;
    endcase
  end

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      accum_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) accum_r <= phase_sel + phase_step_r;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // ---------------- accept: phase select and ROM read ----------------
  assign phase_sel    = in_ch.restart ? start_phase_r : accum_r;
  assign rom_idx      = phase_sel[31:24];
  assign rom_idx_next = rom_idx + 8'd1;

  always_ff @(posedge clk) begin
    if (accept) begin
      phase_r <= phase_sel;
      v0_r    <= SIN_ROM[rom_idx];
      v1_r    <= SIN_ROM[rom_idx_next];
    end
  end

  // ---------------- interpolation multiply ----------------
  // sign-magnitude keeps the truncation toward zero
  assign diff        = {1'b0, v1_r} - {1'b0, v0_r};
  assign diff_mag    = diff[12] ? code_t'(13'd0 - diff) : diff[11:0];
  assign interp_prod = diff_mag * phase_r[23:8];

  always_ff @(posedge clk) begin
    if (state_r == ST_INTERP) begin
      interp_neg_r <= diff[12];
      interp_q_r   <= interp_prod[27:16];
    end
  end

  // ---------------- shape select and amplitude multiply ----------------
  assign tri_pos = phase_r[31:22];
  assign tri_lin = (tri_pos < TRI_HALF) ? tri_pos : (TRI_TOP - tri_pos);

  always_comb begin
    unique case (wave_shape_r)
      SHAPE_TRI:    raw = {tri_lin, 3'b000};
      SHAPE_SQUARE: raw = phase_r[31] ? 13'd0 : {1'b0, MAX_CODE};
      SHAPE_SINE, SHAPE_SINE_X:
        raw = interp_neg_r ? ({1'b0, v0_r} - {1'b0, interp_q_r})
                           : ({1'b0, v0_r} + {1'b0, interp_q_r});
    endcase
  end

  assign gain         = (amp_scale_r > FULL_GAIN) ? FULL_GAIN : amp_scale_r;
  assign centered     = {1'b0, raw} - {2'b00, MID_CODE};
  assign centered_mag = centered[13] ? code_t'(14'd0 - centered) : centered[11:0];
  assign scale_prod   = centered_mag * gain;

  always_ff @(posedge clk) begin
    if (state_r == ST_SCALE) begin
      scale_neg_r <= centered[13];
      scale_q_r   <= scale_prod[27:15];
    end
  end

  // ---------------- recenter, clamp, output register ----------------
  assign sum = scale_neg_r ? ({2'b00, MID_CODE} - {1'b0, scale_q_r})
                           : ({2'b00, MID_CODE} + {1'b0, scale_q_r});

  always_comb begin
    priority if (sum[13])        sample_nxt = '0;
    else if (sum > {2'b00, MAX_CODE}) sample_nxt = MAX_CODE;
    else                          sample_nxt = sum[11:0];
  end

  always_ff @(posedge clk) begin
    if (load_out) sample_r <= sample_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = sample_r;

endmodule
